### sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Types and codes shared by the matrix multiply engine core.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int PRODUCT_W = 35;
	localparam int COUNT_W   = 4;
	localparam int POS_W     = 3;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;

	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_MISMATCH = 1'b1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [POS_W-1:0]  row_index;
		logic [POS_W-1:0]  col_index;
		logic signed [15:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic signed [PRODUCT_W-1:0] product_value;
		logic [POS_W-1:0]            out_row;
		logic [POS_W-1:0]            out_col;
		logic                        status;
		logic                        last_result;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] a_row_count;
		logic [COUNT_W-1:0] a_col_count;
		logic [COUNT_W-1:0] b_row_count;
		logic [COUNT_W-1:0] b_col_count;
	} cfg_regs_t;

	// travels alongside each multiply-accumulate step
	typedef struct packed {
		logic             first;
		logic             last;
		logic             zero;
		logic             err;
		logic             last_result;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} step_tag_t;

endpackage

### sv/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Simple dual-port store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mme_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/mme_seq.sv
// ----------------------------------------------------------------------------
// mme_seq
// Row/col/inner sequencer; issues one store read pair a cycle unless stalled.
// ----------------------------------------------------------------------------
module mme_seq #(
	parameter int MAX_DIM = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  mme_pkg::cfg_regs_t                cfg,
	input  logic                              adv,
	output logic                              busy,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_addr,
	output mme_pkg::step_tag_t                tag
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

	logic             busy_q;
	logic             err_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] j_q;

	logic [CNT_W-1:0] rows;
	logic [CNT_W-1:0] inner;
	logic [CNT_W-1:0] cols;
	logic             mismatch;
	logic             i_end;
	logic             k_end;
	logic             j_end;

	function automatic logic [CNT_W-1:0] clamp(input logic [mme_pkg::COUNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (32'(c) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(c);
		end
		return r;
	endfunction

	always_comb begin
		rows     = clamp(cfg.a_row_count);
		inner    = clamp(cfg.a_col_count);
		cols     = clamp(cfg.b_col_count);
		mismatch = cfg.a_col_count != cfg.b_row_count;
		i_end    = CNT_W'(i_q) == rows - CNT_W'(1);
		k_end    = CNT_W'(k_q) == cols - CNT_W'(1);
		j_end    = (inner == '0) || (CNT_W'(j_q) == inner - CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			err_q  <= 1'b0;
			i_q    <= '0;
			k_q    <= '0;
			j_q    <= '0;
		end else if (!busy_q) begin
			if (start) begin
				i_q <= '0;
				k_q <= '0;
				j_q <= '0;
				if (mismatch) begin
					busy_q <= 1'b1;
					err_q  <= 1'b1;
				end else begin
					busy_q <= (rows != '0) && (cols != '0);
					err_q  <= 1'b0;
				end
			end
		end else if (adv) begin
			if (err_q) begin
				busy_q <= 1'b0;
			end else if (j_end) begin
				j_q <= '0;
				if (k_end) begin
					k_q <= '0;
					if (i_end) begin
						busy_q <= 1'b0;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end else begin
				j_q <= j_q + IDX_W'(1);
			end
		end
	end

	always_comb begin
		busy            = busy_q;
		a_addr          = ADDR_W'(32'(i_q) * MAX_DIM + 32'(j_q));
		b_addr          = ADDR_W'(32'(j_q) * MAX_DIM + 32'(k_q));
		tag.first       = j_q == '0;
		tag.last        = j_end || err_q;
		tag.zero        = inner == '0;
		tag.err         = err_q;
		tag.last_result = err_q || (i_end && k_end && j_end);
		tag.row         = err_q ? '0 : mme_pkg::POS_W'(i_q);
		tag.col         = err_q ? '0 : mme_pkg::POS_W'(k_q);
	end

endmodule

### sv/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// Multiply, accumulate and result register; the whole pipe holds on stall.
// ----------------------------------------------------------------------------
module mme_mac #(
	parameter int ELEMENT_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    issue,
	input  mme_pkg::step_tag_t      tag_s0,
	input  logic [ELEMENT_BITS-1:0] a_rd_s1,
	input  logic [ELEMENT_BITS-1:0] b_rd_s1,
	output logic                    adv,
	output logic                    out_valid,
	input  logic                    out_stall,
	output mme_pkg::out_item_t      out_data
);

	localparam int PROD_W = 2 * ELEMENT_BITS;

	logic                                 v_s1;
	mme_pkg::step_tag_t                   tag_s1;
	logic                                 v_s2;
	mme_pkg::step_tag_t                   tag_s2;
	logic signed [PROD_W-1:0]             prod_s2;
	logic signed [mme_pkg::PRODUCT_W-1:0] acc_q;
	logic signed [mme_pkg::PRODUCT_W-1:0] acc_next;
	logic                                 out_valid_q;
	mme_pkg::out_item_t                   out_q;

	assign adv = !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2 && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
			if (tag_s1.zero || tag_s1.err) begin
				prod_s2 <= '0;
			end else begin
				prod_s2 <= $signed(a_rd_s1) * $signed(b_rd_s1);
			end
		end
	end

	always_comb begin
		acc_next = (tag_s2.first ? '0 : acc_q) + mme_pkg::PRODUCT_W'(prod_s2);
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= acc_next;
			if (tag_s2.last) begin
				out_q.product_value <= tag_s2.err ? '0 : acc_next;
				out_q.out_row       <= tag_s2.row;
				out_q.out_col       <= tag_s2.col;
				out_q.status        <= tag_s2.err ? mme_pkg::STATUS_MISMATCH
				                                  : mme_pkg::STATUS_OK;
				out_q.last_result   <= tag_s2.last_result;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### sv/matrix_multiply_engine_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// Loads A and B element-wise into two stores, then streams C = A x B.
//
//   channel  signals                         direction  transaction
//   in       in_valid, in_stall, in_data     sink       load A, load B, start
//   out      out_valid, out_stall, out_data  source     one C element or error
//   cfg      cfg_valid, cfg_ready, cfg_*     sink       count register write
//
// Loads are accepted back to back while idle. A start holds in_stall while
// the core issues rows x cols x max(inner,1) multiply-accumulates, one per
// cycle unless out_stall holds the pipe, as set by the single read port of
// each store; results go through s1, s2 and out_q. A mismatch issues one step.
// Reset clears control and sets all counts to 8; the stores are not cleared.
// out_stall with out_valid high freezes the sequencer and the whole MAC pipe.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core #(
	parameter int MAX_DIM      = 8,
	parameter int ELEMENT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mme_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mme_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [mme_pkg::COUNT_W-1:0]         cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	mme_pkg::cfg_regs_t      cfg_q;
	logic                    accept;
	logic                    in_range;
	logic                    start;
	logic                    busy;
	logic                    adv;
	logic                    we_a;
	logic                    we_b;
	logic [ADDR_W-1:0]       waddr;
	logic [ELEMENT_BITS-1:0] wdata;
	logic [ADDR_W-1:0]       a_addr;
	logic [ADDR_W-1:0]       b_addr;
	logic [ELEMENT_BITS-1:0] a_rd;
	logic [ELEMENT_BITS-1:0] b_rd;
	mme_pkg::step_tag_t      tag;
	logic                    rd_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_row_count <= mme_pkg::COUNT_W'(8);
			cfg_q.a_col_count <= mme_pkg::COUNT_W'(8);
			cfg_q.b_row_count <= mme_pkg::COUNT_W'(8);
			cfg_q.b_col_count <= mme_pkg::COUNT_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mme_pkg::REG_A_ROWS: cfg_q.a_row_count <= cfg_data;
				mme_pkg::REG_A_COLS: cfg_q.a_col_count <= cfg_data;
				mme_pkg::REG_B_ROWS: cfg_q.b_row_count <= cfg_data;
				mme_pkg::REG_B_COLS: cfg_q.b_col_count <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		in_stall = busy;
		accept   = in_valid && !in_stall;
		in_range = (32'(in_data.row_index) < MAX_DIM) && (32'(in_data.col_index) < MAX_DIM);
		we_a     = accept && in_range && (in_data.cmd == mme_pkg::CMD_LOAD_A);
		we_b     = accept && in_range && (in_data.cmd == mme_pkg::CMD_LOAD_B);
		start    = accept && (in_data.cmd == mme_pkg::CMD_START);
		waddr    = ADDR_W'(32'(in_data.row_index) * MAX_DIM + 32'(in_data.col_index));
		wdata    = ELEMENT_BITS'(in_data.element_value[15:0]);
		rd_en    = adv;
	end

	mme_ram #(.DEPTH(DEPTH), .WIDTH(ELEMENT_BITS)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (a_addr),
		.rdata (a_rd)
	);

	mme_ram #(.DEPTH(DEPTH), .WIDTH(ELEMENT_BITS)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (b_addr),
		.rdata (b_rd)
	);

	mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg    (cfg_q),
		.adv    (adv),
		.busy   (busy),
		.a_addr (a_addr),
		.b_addr (b_addr),
		.tag    (tag)
	);

	mme_mac #(.ELEMENT_BITS(ELEMENT_BITS)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (busy),
		.tag_s0    (tag),
		.a_rd_s1   (a_rd),
		.b_rd_s1   (b_rd),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
